>>> rtl/mmkh_pkg.sv
// Shared constants, handshake structs and helpers for the MurmurHash64A key hasher.
package mmkh_pkg;

   localparam logic [63:0] MIX_MULT  = 64'hc6a4a7935bd1e995;
   localparam int unsigned MIX_SHIFT = 47;

   typedef struct packed {
      logic        start;
      logic [63:0] operand;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

   // keep the low count bytes of a word
   function automatic logic [63:0] byte_mask(input logic [3:0] count);
      logic [63:0] mask;
      mask = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < count) begin
            mask[8*i +: 8] = 8'hff;
         end
      end
      return mask;
   endfunction

endpackage

>>> rtl/murmur64a_key_hash_top.sv
// Top level of the streaming MurmurHash64A key hasher.
// Every 64-bit multiply runs through the LL, HL and LH partial-product steps of the shared 32x32 multiplier unit.
// Each beat runs M multiplies, and the next beat is stalled until they are through: +1 on a key's
// first beat (length seed), +3 for a full word, +1 for a partial word, +1 on the last beat.
// A last beat also passes the hand-off state to load the result register; the result waits there for the sink.
// Reset (synchronous, active high) clears the sequencer, the result valid and the seed to zero.
module murmur64a_key_hash_top
   import mmkh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // key word beats
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_key_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last,
   input  logic [31:0] req_key_length,
   // hash result beats
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value,
   // seed register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_hash_seed
);

   // Sequencer states: each multiply state waits for the shared unit to finish.
   localparam logic [2:0] S_IDLE = 3'd0;  // take a beat
   localparam logic [2:0] S_LEN  = 3'd1;  // length * mult for the seed
   localparam logic [2:0] S_K1   = 3'd2;  // word * mult
   localparam logic [2:0] S_K2   = 3'd3;  // (k ^ k>>47) * mult
   localparam logic [2:0] S_H    = 3'd4;  // fold: h * mult
   localparam logic [2:0] S_FIN  = 3'd5;  // finalize: (h ^ h>>47) * mult
   localparam logic [2:0] S_OUT  = 3'd6;  // hand the hash to the result register

   logic [2:0]  state_ff, state_in;
   logic        first_ff, first_in;
   logic [31:0] seed_ff, seed_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] word_ff, word_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_hash_ff, rsp_hash_in;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   logic        accept;
   logic        in_idle;
   logic [63:0] word_cur;
   logic [3:0]  cnt_cur;
   logic        last_cur;
   logic        cnt_full;
   logic        cnt_none;
   logic        enter_data;
   logic        enter_tail;
   logic [63:0] h_a;
   logic [63:0] h_t;
   logic [63:0] k_mix;
   logic        slot_free;

   mmkh_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // Only the idle state takes a beat; the seed register is always writable.
   assign in_idle   = (state_ff == S_IDLE);
   assign req_stall = !in_idle;
   assign accept    = req_valid && in_idle;
   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // In the accept cycle work straight off the ports; later off the held copy.
   assign word_cur = in_idle ? req_key_word   : word_ff;
   assign cnt_cur  = in_idle ? req_byte_count : cnt_ff;
   assign last_cur = in_idle ? req_last       : last_ff;
   assign cnt_full = cnt_cur[3];          // eight or more bytes: full word
   assign cnt_none = (cnt_cur == 4'd0);

   // Seed phase done: either a continuing key, or the length multiply returned.
   assign enter_data = (accept && !first_ff) || (state_ff == S_LEN && mul_rsp.done);
   assign h_a        = (state_ff == S_LEN) ? ({32'b0, seed_ff} ^ mul_rsp.product) : h_ff;

   // Data phase done: nothing to fold, or the fold multiply returned.
   assign enter_tail = (enter_data && cnt_none) || (state_ff == S_H && mul_rsp.done);
   assign h_t        = (state_ff == S_H) ? mul_rsp.product : h_a;

   assign k_mix = mul_rsp.product ^ (mul_rsp.product >> MIX_SHIFT);

   always_comb begin
      state_in        = state_ff;
      first_in        = first_ff;
      h_in            = h_ff;
      word_in         = word_ff;
      cnt_in          = cnt_ff;
      last_in         = last_ff;
      mul_req.start   = 1'b0;
      mul_req.operand = h_ff;

      // latch the beat and, on a key's first beat, open a new key with the length multiply
      if (accept) begin
         word_in = req_key_word;
         cnt_in  = req_byte_count;
         last_in = req_last;
         if (first_ff) begin
            mul_req.start   = 1'b1;
            mul_req.operand = {32'b0, req_key_length};
            state_in        = S_LEN;
         end
      end

      // fold the word: full words go through the mix, partial words are masked
      if (enter_data && !cnt_none) begin
         mul_req.start = 1'b1;
         if (cnt_full) begin
            mul_req.operand = word_cur;
            h_in            = h_a;
            state_in        = S_K1;
         end else begin
            mul_req.operand = h_a ^ (word_cur & byte_mask(cnt_cur));
            state_in        = S_H;
         end
      end

      if (state_ff == S_K1 && mul_rsp.done) begin
         mul_req.start   = 1'b1;
         mul_req.operand = k_mix;
         state_in        = S_K2;
      end

      if (state_ff == S_K2 && mul_rsp.done) begin
         mul_req.start   = 1'b1;
         mul_req.operand = h_ff ^ mul_rsp.product;
         state_in        = S_H;
      end

      // end of beat: finalize on last, else hold the running hash
      if (enter_tail) begin
         if (last_cur) begin
            mul_req.start   = 1'b1;
            mul_req.operand = h_t ^ (h_t >> MIX_SHIFT);
            state_in        = S_FIN;
         end else begin
            h_in     = h_t;
            first_in = 1'b0;
            state_in = S_IDLE;
         end
      end

      if (state_ff == S_FIN && mul_rsp.done) begin
         h_in     = k_mix;
         state_in = S_OUT;
      end

      // drop the hash into the result register once it is free
      if (state_ff == S_OUT && slot_free) begin
         first_in = 1'b1;
         state_in = S_IDLE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      if (state_ff == S_OUT && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_hash_in  = h_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign seed_in = (csr_valid && csr_ready) ? csr_hash_seed : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= 1'b1;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      h_ff        <= h_in;
      word_ff     <= word_in;
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   // The multiplier only reports back while the sequencer is waiting on it.
   a_mul_done_expected : assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == S_LEN || state_ff == S_K1 || state_ff == S_K2 ||
                        state_ff == S_H || state_ff == S_FIN))
      else $error("multiplier result with no sequencer state waiting");

   // A new result only comes out of the hand-off state.
   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result loaded outside the hand-off state");

   // An accepted beat starts work on the sequencer, unless it is an empty, non-last beat of a continuing key.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (accept && !(req_byte_count == 4'd0 && !req_last && !first_ff)) |=> !in_idle)
      else $error("accepted beat did not start the sequencer");

endmodule

>>> rtl/mmkh_mul.sv
// Iterative 64x64 (low half) multiply by the mix constant on one 32x32 multiplier.
module mmkh_mul
   import mmkh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   localparam logic [2:0] STEP_IDLE = 3'd0;
   localparam logic [2:0] STEP_LL   = 3'd1;
   localparam logic [2:0] STEP_HL   = 3'd2;
   localparam logic [2:0] STEP_LH   = 3'd3;
   localparam logic [2:0] STEP_DONE = 3'd4;

   localparam logic [31:0] MULT_LO = MIX_MULT[31:0];
   localparam logic [31:0] MULT_HI = MIX_MULT[63:32];

   logic [2:0]  step_ff, step_in;
   logic [63:0] opa_ff, opa_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] mul_x, mul_y;
   logic [63:0] prod;

   // operand select for the single shared multiplier
   always_comb begin
      mul_x = opa_ff[31:0];
      mul_y = MULT_LO;
      case (step_ff)
         STEP_HL: begin
            mul_x = opa_ff[63:32];
            mul_y = MULT_LO;
         end
         STEP_LH: begin
            mul_x = opa_ff[31:0];
            mul_y = MULT_HI;
         end
         default: begin
            mul_x = opa_ff[31:0];
            mul_y = MULT_LO;
         end
      endcase
   end

   assign prod = mul_x * mul_y;

   always_comb begin
      step_in = step_ff;
      opa_in  = opa_ff;
      acc_in  = acc_ff;
      case (step_ff)
         STEP_IDLE: begin
            if (mul_req.start) begin
               opa_in  = mul_req.operand;
               step_in = STEP_LL;
            end
         end
         STEP_LL: begin
            acc_in  = prod;
            step_in = STEP_HL;
         end
         STEP_HL: begin
            acc_in[63:32] = acc_ff[63:32] + prod[31:0];
            step_in       = STEP_LH;
         end
         STEP_LH: begin
            acc_in[63:32] = acc_ff[63:32] + prod[31:0];
            step_in       = STEP_DONE;
         end
         STEP_DONE: begin
            // a chained request may arrive in the same cycle as the result
            if (mul_req.start) begin
               opa_in  = mul_req.operand;
               step_in = STEP_LL;
            end else begin
               step_in = STEP_IDLE;
            end
         end
         default: begin
            step_in = STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
      opa_ff <= opa_in;
      acc_ff <= acc_in;
   end

   assign mul_rsp.done    = (step_ff == STEP_DONE);
   assign mul_rsp.product = acc_ff;

endmodule
